// ----- sv/otk_pkg.sv -----
// ----------------------------------------------------------------------------
// otk_pkg
// Shared constants and types for the 1-Wire temperature to microkelvin
// decoder: scale factors, divider geometry and the divider stage payload.
// ----------------------------------------------------------------------------
package otk_pkg;

    localparam logic [31:0] KELVIN_UK    = 32'd273150000;
    localparam logic [31:0] QUARTER_UK   = 32'd250000;
    localparam logic [19:0] SIXTEENTH_UK = 20'd62500;
    localparam logic [19:0] HALF_UK      = 20'd500000;
    localparam logic [19:0] DEGREE_UK    = 20'd1000000;

    localparam int NUM_W        = 28;
    localparam int DIV_STEP     = 4;
    localparam int DIV_STAGES   = NUM_W / DIV_STEP;

    localparam logic FMT_SIXTEENTH = 1'b0;
    localparam logic FMT_HALF      = 1'b1;

    typedef struct packed {
        logic [31:0]      base;
        logic             neg;
        logic [7:0]       divisor;
        logic [7:0]       rem;
        logic [NUM_W-1:0] num;
    } t_div_pl;

endpackage

// ----- sv/otk_front.sv -----
// ----------------------------------------------------------------------------
// otk_front
// Three front stages: capture of the scratchpad bytes, the two scale
// multiplications, and the Kelvin offset addition that seeds the divider.
// ----------------------------------------------------------------------------
module otk_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [31:0]      i_tdata,
    input  logic             i_fmt,
    output logic             o_valid,
    output otk_pkg::t_div_pl o_pl
);

    logic                r_a_valid;
    logic signed [15:0]  r_a_raw;
    logic [7:0]          r_a_remain;
    logic [7:0]          r_a_per;
    logic                r_a_fmt;

    logic                r_b_valid;
    logic [31:0]         r_b_prod;
    logic [27:0]         r_b_num;
    logic                r_b_neg;
    logic [7:0]          r_b_div;
    logic                r_b_interp;

    logic                r_c_valid;
    otk_pkg::t_div_pl    r_c_pl;

    logic                n_interp;
    logic signed [15:0]  n_sel;
    logic [19:0]         n_coef;
    logic signed [36:0]  n_prod;
    logic signed [8:0]   n_diff;
    logic [7:0]          n_mag;
    logic [27:0]         n_num;
    otk_pkg::t_div_pl    n_c_pl;

    always_comb begin
        n_interp = (r_a_fmt == otk_pkg::FMT_HALF) && (r_a_per != 8'd0);
        n_sel    = n_interp ? {r_a_raw[15:1], 1'b0} : r_a_raw;
        n_coef   = (r_a_fmt == otk_pkg::FMT_HALF) ? otk_pkg::HALF_UK : otk_pkg::SIXTEENTH_UK;
        n_prod   = n_sel * $signed({1'b0, n_coef});
        n_diff   = $signed({1'b0, r_a_per}) - $signed({1'b0, r_a_remain});
        n_mag    = n_diff[8] ? 8'(-n_diff) : n_diff[7:0];
        n_num    = n_interp ? ({20'd0, n_mag} * {8'd0, otk_pkg::DEGREE_UK}) : 28'd0;
    end

    always_comb begin
        n_c_pl.base    = r_b_prod + (r_b_interp ? (otk_pkg::KELVIN_UK - otk_pkg::QUARTER_UK)
                                                : otk_pkg::KELVIN_UK);
        n_c_pl.neg     = r_b_neg;
        n_c_pl.divisor = r_b_div;
        n_c_pl.rem     = 8'd0;
        n_c_pl.num     = r_b_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_raw    <= $signed(i_tdata[15:0]);
            r_a_remain <= i_tdata[23:16];
            r_a_per    <= i_tdata[31:24];
            r_a_fmt    <= i_fmt;
            r_b_prod   <= n_prod[31:0];
            r_b_num    <= n_num;
            r_b_neg    <= n_interp & n_diff[8];
            r_b_div    <= n_interp ? r_a_per : 8'd1;
            r_b_interp <= n_interp;
            r_c_pl     <= n_c_pl;
        end
    end

    assign o_valid = r_c_valid;
    assign o_pl    = r_c_pl;

endmodule

// ----- sv/otk_div_stage.sv -----
// ----------------------------------------------------------------------------
// otk_div_stage
// One registered stage of the restoring divider, retiring four quotient bits
// per cycle, while i_adv is high, into the low end of the shifting dividend.
// ----------------------------------------------------------------------------
module otk_div_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  otk_pkg::t_div_pl i_pl,
    output logic             o_valid,
    output otk_pkg::t_div_pl o_pl
);

    logic             r_valid;
    otk_pkg::t_div_pl r_pl;
    otk_pkg::t_div_pl n_pl;

    always_comb begin
        logic [8:0] trial;
        n_pl = i_pl;
        for (int k = 0; k < otk_pkg::DIV_STEP; k++) begin
            trial = {n_pl.rem, n_pl.num[otk_pkg::NUM_W-1]};
            if (trial >= {1'b0, n_pl.divisor}) begin
                n_pl.rem = 8'(trial - {1'b0, n_pl.divisor});
                n_pl.num = {n_pl.num[otk_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_pl.rem = trial[7:0];
                n_pl.num = {n_pl.num[otk_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pl <= n_pl;
        end
    end

    assign o_valid = r_valid;
    assign o_pl    = r_pl;

endmodule

// ----- sv/onewire_temp_to_microkelvin.sv -----
// ----------------------------------------------------------------------------
// onewire_temp_to_microkelvin
// Accepts one item per cycle while the pipeline advances. The whole pipeline
// (capture, multiply, offset, seven divider stages of four quotient bits
// each, output register) advances together whenever the output register is
// empty or being taken.
// Reset is synchronous and active low; it clears all valid bits and sets
// sensor_format to the sixteenth-degree format.
// ----------------------------------------------------------------------------
module onewire_temp_to_microkelvin (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // temp_low_byte[7:0], temp_high_byte[15:8], remaining_count[23:16],
    // count_per_degree[31:24]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // temp_microkelvin[31:0]
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             r_fmt;
    logic             r_out_valid;
    logic [31:0]      r_out_data;
    logic             adv;
    logic             div_valid [0:otk_pkg::DIV_STAGES];
    otk_pkg::t_div_pl div_pl    [0:otk_pkg::DIV_STAGES];
    logic [31:0]      n_out_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_fmt} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= otk_pkg::FMT_SIXTEENTH;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_fmt <= pwdata[0];
        end
    end

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;

    otk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s_axis_tvalid),
        .i_tdata (s_axis_tdata),
        .i_fmt   (r_fmt),
        .o_valid (div_valid[0]),
        .o_pl    (div_pl[0])
    );

    for (genvar g = 0; g < otk_pkg::DIV_STAGES; g++) begin : g_div
        otk_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (div_valid[g]),
            .i_pl    (div_pl[g]),
            .o_valid (div_valid[g+1]),
            .o_pl    (div_pl[g+1])
        );
    end

    always_comb begin
        logic [31:0] quot;
        quot       = {4'd0, div_pl[otk_pkg::DIV_STAGES].num};
        n_out_data = div_pl[otk_pkg::DIV_STAGES].base
                   + (div_pl[otk_pkg::DIV_STAGES].neg ? (32'd0 - quot) : quot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= div_valid[otk_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- sv/otk_checker.sv -----
// ----------------------------------------------------------------------------
// otk_checker
// Port-level checks of the decoder: output hold under stall, ready
// derivation, reset clearing and register write-back.
// ----------------------------------------------------------------------------
module otk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stage");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == 1'b0)
        |=> (paddr[2] != 1'b0) || (prdata[0] == $past(pwdata[0])))
        else $error("format register readback mismatch");

endmodule

bind onewire_temp_to_microkelvin otk_checker u_otk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
